// ----- rtl/core/kmc_pkg.sv -----
// shared constants, command codes and base coding for the k-mer histogram counter
package kmc_pkg;

	localparam int MAX_K_DEF      = 10;
	localparam int COUNT_BITS_DEF = 32;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int RIDX_W = 20;
	localparam int OCNT_W = 32;
	localparam int KLEN_W = 4;
	localparam int KCMP_W = 5;

	localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(3);
	localparam logic [KCMP_W-1:0] MIN_K      = KCMP_W'(3);

	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	typedef enum logic [1:0] {
		CODE_A = 2'd0,
		CODE_C = 2'd1,
		CODE_G = 2'd2,
		CODE_T = 2'd3
	} base_code_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_BASE = 2'd0,
		CMD_END  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	function automatic base_code_t base_code(input logic [CHAR_W-1:0] ch);
		base_code_t code;
		case (ch)
			CHAR_C:  code = CODE_C;
			CHAR_G:  code = CODE_G;
			CHAR_T:  code = CODE_T;
			default: code = CODE_A;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/core/kmer_histogram_counter.sv -----
// Usage: counts overlapping k-mers of base streams in an on-chip count memory.
// Input channel (in_valid / in_stall): cmd selects a base beat (base_char), an
// end-of-sequence beat, or a read beat (read_index). Only read beats produce a
// result on the output channel (out_valid / out_stall) as kmer_count and
// kmer_index. Config channel (cfg_valid / cfg_ready) writes kmer_length; write
// it only while no beat is in flight. Lengths below 3 act as 3, above MAX_K
// as MAX_K.
// Throughput: one input beat per cycle while in_stall is low. Each counted
// base does a read-modify-write of the count memory (read at accept,
// increment and write in the next cycle); a back-to-back hit on the same
// entry is forwarded from the write. Reads pass the memory and output stages.
// Reset: asynchronous, clears the window and the length to 3, then a clearing
// pass zeroes all 4^MAX_K (1048576 at MAX_K = 10) count memory entries, one
// entry per cycle, with in_stall high throughout.
// Stall: the result stays in the output register; one more read beat may wait
// in the memory stage, after which in_stall is raised until out_stall drops.
module kmer_histogram_counter #(
	parameter int MAX_K      = kmc_pkg::MAX_K_DEF,
	parameter int COUNT_BITS = kmc_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kmc_pkg::KLEN_W-1:0]  kmer_length,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kmc_pkg::CMD_W-1:0]   cmd,
	input  logic [kmc_pkg::CHAR_W-1:0]  base_char,
	input  logic [kmc_pkg::RIDX_W-1:0]  read_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kmc_pkg::OCNT_W-1:0]  kmer_count,
	output logic [kmc_pkg::RIDX_W-1:0]  kmer_index
);
	import kmc_pkg::*;

	localparam int INDEX_BITS = 2 * MAX_K;
	localparam longint unsigned DEPTH = 64'd1 << INDEX_BITS;
	localparam int HELD_W = $clog2(MAX_K + 1);
	localparam int RI_EXT_W = (INDEX_BITS > RIDX_W) ? INDEX_BITS : RIDX_W;

	logic [KLEN_W-1:0]     klen_q;
	logic [INDEX_BITS-1:0] window_q;
	logic [HELD_W-1:0]     held_q;
	logic                  clearing_q;
	logic [INDEX_BITS-1:0] clr_addr_q;

	logic                  op_valid_s1;
	logic                  op_read_s1;
	logic [INDEX_BITS-1:0] op_idx_s1;
	logic                  fwd_hit_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;

	logic                  out_valid_q;
	logic [OCNT_W-1:0]     out_count_q;
	logic [RIDX_W-1:0]     out_index_q;

	logic [COUNT_BITS-1:0] count_mem [DEPTH];

	logic [KCMP_W-1:0]     k_req;
	logic [KCMP_W-1:0]     k_eff;
	logic [INDEX_BITS-1:0] win_next;
	logic [HELD_W-1:0]     held_next;
	logic                  count_hit;
	logic [INDEX_BITS-1:0] kmask;
	logic [INDEX_BITS-1:0] inc_idx;
	logic [RI_EXT_W-1:0]   ri_ext;
	logic [INDEX_BITS-1:0] rd_idx;
	logic                  is_base;
	logic                  is_read;
	logic                  accept;
	logic                  op_new;
	logic [INDEX_BITS-1:0] op_idx_new;
	logic [COUNT_BITS-1:0] cur_s1;
	logic [COUNT_BITS-1:0] sum_s1;
	logic                  out_free;
	logic                  s1_done;
	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	// effective length and window index, two bits of index per base
	always_comb begin
		k_req = KCMP_W'(klen_q);
		if (k_req < MIN_K) begin
			k_eff = MIN_K;
		end else if (k_req > KCMP_W'(MAX_K)) begin
			k_eff = KCMP_W'(MAX_K);
		end else begin
			k_eff = k_req;
		end
		for (int i = 0; i < INDEX_BITS; i++) begin
			kmask[i] = (6'(i) < {k_eff, 1'b0});
		end
	end

	assign win_next  = {window_q[INDEX_BITS-3:0], base_code(base_char)};
	assign held_next = (held_q < HELD_W'(MAX_K)) ? held_q + 1'b1 : held_q;
	assign count_hit = (KCMP_W'(held_next) >= k_eff);
	assign inc_idx   = win_next & kmask;
	assign ri_ext    = RI_EXT_W'(read_index);
	assign rd_idx    = ri_ext[INDEX_BITS-1:0];

	assign is_base    = (cmd == CMD_BASE);
	assign is_read    = (cmd == CMD_READ);
	assign op_new     = (is_base && count_hit) || is_read;
	assign op_idx_new = is_read ? rd_idx : inc_idx;

	assign cur_s1 = fwd_hit_s1 ? fwd_data_s1 : rd_data_s1;
	assign sum_s1 = (cur_s1 == '1) ? cur_s1 : cur_s1 + 1'b1;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_done  = !op_valid_s1 || !op_read_s1 || out_free;
	assign in_stall = clearing_q || !s1_done;
	assign accept   = in_valid && !in_stall;

	assign wr_en   = clearing_q || (op_valid_s1 && !op_read_s1);
	assign wr_addr = clearing_q ? clr_addr_q : op_idx_s1;
	assign wr_data = clearing_q ? '0 : sum_s1;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign kmer_count = out_count_q;
	assign kmer_index = out_index_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q      <= KLEN_RESET;
			window_q    <= '0;
			held_q      <= '0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			op_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				klen_q <= kmer_length;
			end
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				unique case (cmd)
					CMD_BASE: begin
						window_q <= win_next;
						held_q   <= held_next;
					end
					CMD_END: begin
						window_q <= '0;
						held_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				op_valid_s1 <= op_new;
			end else if (s1_done) begin
				op_valid_s1 <= 1'b0;
			end
			if (op_valid_s1 && op_read_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// memory stage payload with forwarding from the write in flight, and output register payload
	always_ff @(posedge clk) begin
		if (accept && op_new) begin
			op_read_s1  <= is_read;
			op_idx_s1   <= op_idx_new;
			fwd_hit_s1  <= op_valid_s1 && !op_read_s1 && (op_idx_s1 == op_idx_new);
			fwd_data_s1 <= sum_s1;
		end
		if (op_valid_s1 && op_read_s1 && out_free) begin
			out_count_q <= OCNT_W'(cur_s1);
			out_index_q <= RIDX_W'(op_idx_s1);
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (accept && op_new) begin
			rd_data_s1 <= count_mem[op_idx_new];
		end
		if (wr_en) begin
			count_mem[wr_addr] <= wr_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_op_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !op_valid_s1)
		else $error("memory operation during clearing pass");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op_valid_s1 && op_read_s1))
		else $error("result without a read in the memory stage");

	a_read_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid_s1 && op_read_s1 && out_valid_q && out_stall)
		|=> (op_valid_s1 && op_read_s1 && $stable(op_idx_s1)))
		else $error("pending read lost while output stalled");

	a_fwd_after_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_new && op_valid_s1 && !op_read_s1 && (op_idx_s1 == op_idx_new))
		|=> fwd_hit_s1)
		else $error("same-entry update not forwarded");
`endif

endmodule
